// File: rtl/core/vcb_pkg.sv
`timescale 1ns / 1ps
// vcb_pkg: types and constants of the vertex cache batcher
// used by vertex_cache_batcher and its testbench
package vcb_pkg;

  localparam int CACHE_SLOTS_DEF     = 32;
  localparam int VERTEX_IDS_DEF      = 255;
  localparam int BATCH_TRIANGLES_DEF = 32;

  localparam int ID_W   = 8;
  localparam int SLOT_W = 5;
  localparam int CNT_W  = 6;
  localparam int TRI_W  = 3 * ID_W;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_TRI1 = 2'd1;
  localparam logic [1:0] CMD_TRI2 = 2'd2;
  localparam logic [1:0] CMD_END  = 2'd3;

  localparam logic REQ_TRI = 1'b0;
  localparam logic REQ_END = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INS,
    S_SCAN,
    S_LOAD,
    S_TBAT,
    S_TCOR,
    S_TEMIT,
    S_END
  } state_t;

endpackage

// File: rtl/core/vcb_ram.sv
`timescale 1ns / 1ps
// vcb_ram: generic single write, single read ram with registered read data
// depends on nothing
module vcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: rtl/core/vertex_cache_batcher.sv
`timescale 1ns / 1ps
// Vertex cache batcher: takes one word at a time. A triangle that needs no flush
// goes through accept, check and three map update steps (through the single map
// write port). A flush scans every vertex id once, one id a cycle unless a load
// command waits on the output, emits the last load run, then reads each stored
// triangle from the batch and map and emits one command per triangle pair (TRI1 for a
// lone last one), waiting out any output stall. Needs vcb_pkg and vcb_ram.
module vertex_cache_batcher
  import vcb_pkg::*;
#(
  parameter int CACHE_SLOTS     = CACHE_SLOTS_DEF,
  parameter int VERTEX_IDS      = VERTEX_IDS_DEF,
  parameter int BATCH_TRIANGLES = BATCH_TRIANGLES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_req_type,
  input  logic [ID_W-1:0]   in_corner_a,
  input  logic [ID_W-1:0]   in_corner_b,
  input  logic [ID_W-1:0]   in_corner_c,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_cmd_kind,
  output logic [ID_W-1:0]   out_first_vertex,
  output logic [CNT_W-1:0]  out_load_count,
  output logic [SLOT_W-1:0] out_dest_slot,
  output logic [SLOT_W-1:0] out_tri0_s0,
  output logic [SLOT_W-1:0] out_tri0_s1,
  output logic [SLOT_W-1:0] out_tri0_s2,
  output logic [SLOT_W-1:0] out_tri1_s0,
  output logic [SLOT_W-1:0] out_tri1_s1,
  output logic [SLOT_W-1:0] out_tri1_s2,
  output logic              out_last
);

  localparam int VID_AW = $clog2(VERTEX_IDS);
  localparam int BT_AW  = (BATCH_TRIANGLES > 1) ? $clog2(BATCH_TRIANGLES) : 1;

  state_t state_r, state_nxt;

  logic              req_r, req_nxt;
  logic [ID_W-1:0]   id_r [3];
  logic [ID_W-1:0]   id_nxt [3];
  logic [VERTEX_IDS-1:0] vld_r, vld_nxt;
  logic [CNT_W-1:0]  slots_r, slots_nxt;
  logic [CNT_W-1:0]  bcnt_r, bcnt_nxt;
  logic [1:0]        c_r, c_nxt;
  logic [VID_AW-1:0] sid_r, sid_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  rstart_r, rstart_nxt;
  logic [ID_W-1:0]   rfirst_r, rfirst_nxt;
  logic [ID_W-1:0]   prev_r, prev_nxt;
  logic [CNT_W-1:0]  t_r, t_nxt;
  logic              half_r, half_nxt;
  logic [SLOT_W-1:0] s_r [6];
  logic [SLOT_W-1:0] s_nxt [6];

  logic              ov_r, ov_nxt;
  logic [1:0]        okind_r, okind_nxt;
  logic [ID_W-1:0]   ofirst_r, ofirst_nxt;
  logic [CNT_W-1:0]  ocount_r, ocount_nxt;
  logic [SLOT_W-1:0] odest_r, odest_nxt;
  logic [SLOT_W-1:0] ot_r [6];
  logic [SLOT_W-1:0] ot_nxt [6];
  logic              olast_r, olast_nxt;

  logic              map_we;
  logic [VID_AW-1:0] map_waddr, map_raddr;
  logic [SLOT_W-1:0] map_wdata, map_rdata;
  logic              bat_we;
  logic [TRI_W-1:0]  bat_wdata, bat_rdata;

  logic              out_free, bad, over, scan_v, scan_brk, scan_stall;
  logic              tri_done, emit_last;
  logic [1:0]        needed;
  logic [ID_W-1:0]   cur_id, bat_id;
  logic [2:0]        sidx;

  function automatic logic vld_at(input logic [VERTEX_IDS-1:0] v, input logic [ID_W-1:0] id);
    vld_at = (32'(id) < VERTEX_IDS) && v[id[VID_AW-1:0]];
  endfunction

  vcb_ram #(.WIDTH(SLOT_W), .DEPTH(VERTEX_IDS)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  vcb_ram #(.WIDTH(TRI_W), .DEPTH(BATCH_TRIANGLES)) u_bat (
    .clk(clk), .we(bat_we), .waddr(bcnt_r[BT_AW-1:0]), .wdata(bat_wdata),
    .raddr(t_r[BT_AW-1:0]), .rdata(bat_rdata)
  );

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = ov_r;
  assign out_cmd_kind     = okind_r;
  assign out_first_vertex = ofirst_r;
  assign out_load_count   = ocount_r;
  assign out_dest_slot    = odest_r;
  assign out_tri0_s0      = ot_r[0];
  assign out_tri0_s1      = ot_r[1];
  assign out_tri0_s2      = ot_r[2];
  assign out_tri1_s0      = ot_r[3];
  assign out_tri1_s1      = ot_r[4];
  assign out_tri1_s2      = ot_r[5];
  assign out_last         = olast_r;

  assign out_free   = !ov_r || out_ready;
  assign bad        = (32'(id_r[0]) >= VERTEX_IDS) || (32'(id_r[1]) >= VERTEX_IDS) ||
                      (32'(id_r[2]) >= VERTEX_IDS);
  assign needed     = 2'(!vld_at(vld_r, id_r[0])) + 2'(!vld_at(vld_r, id_r[1])) +
                      2'(!vld_at(vld_r, id_r[2]));
  assign over       = (32'(needed) + 32'(slots_r) > CACHE_SLOTS) ||
                      (32'(bcnt_r) >= BATCH_TRIANGLES);
  assign cur_id     = id_r[c_r];
  assign scan_v     = vld_r[sid_r];
  assign scan_brk   = scan_v && (k_r != '0) && (ID_W'(sid_r) != prev_r + 8'd1);
  assign scan_stall = scan_brk && !out_free;
  assign tri_done   = (t_r + 6'd1 >= bcnt_r);
  assign emit_last  = tri_done && (req_r != REQ_END);
  assign bat_id     = (c_r == 2'd0) ? bat_rdata[7:0] :
                      (c_r == 2'd1) ? bat_rdata[15:8] : bat_rdata[23:16];
  assign sidx       = half_r ? 3'(c_r) + 3'd2 : 3'(c_r) - 3'd1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CHECK;
      S_CHECK: begin
        if (req_r == REQ_END) begin
          state_nxt = (bcnt_r == '0) ? S_END : S_SCAN;
        end else if (bad) begin
          state_nxt = S_IDLE;
        end else if (over && bcnt_r != '0) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_INS:   if (c_r == 2'd2) state_nxt = S_IDLE;
      S_SCAN:  if (!scan_stall && 32'(sid_r) == VERTEX_IDS - 1) state_nxt = S_LOAD;
      S_LOAD:  if (out_free) state_nxt = S_TBAT;
      S_TBAT:  state_nxt = S_TCOR;
      S_TCOR: begin
        if (c_r == 2'd3) begin
          state_nxt = (!half_r && !tri_done) ? S_TBAT : S_TEMIT;
        end
      end
      S_TEMIT: begin
        if (out_free) begin
          if (!tri_done) state_nxt = S_TBAT;
          else state_nxt = (req_r == REQ_END) ? S_END : S_INS;
        end
      end
      S_END:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    req_nxt    = req_r;
    id_nxt     = id_r;
    vld_nxt    = vld_r;
    slots_nxt  = slots_r;
    bcnt_nxt   = bcnt_r;
    c_nxt      = c_r;
    sid_nxt    = sid_r;
    k_nxt      = k_r;
    rstart_nxt = rstart_r;
    rfirst_nxt = rfirst_r;
    prev_nxt   = prev_r;
    t_nxt      = t_r;
    half_nxt   = half_r;
    s_nxt      = s_r;
    ov_nxt     = ov_r && !out_ready;
    okind_nxt  = okind_r;
    ofirst_nxt = ofirst_r;
    ocount_nxt = ocount_r;
    odest_nxt  = odest_r;
    ot_nxt     = ot_r;
    olast_nxt  = olast_r;
    map_we     = 1'b0;
    map_waddr  = cur_id[VID_AW-1:0];
    map_wdata  = slots_r[SLOT_W-1:0];
    map_raddr  = bat_id[VID_AW-1:0];
    bat_we     = 1'b0;
    bat_wdata  = {id_r[2], id_r[1], id_r[0]};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req_type;
          id_nxt[0] = in_corner_a;
          id_nxt[1] = in_corner_b;
          id_nxt[2] = in_corner_c;
        end
        c_nxt    = '0;
        sid_nxt  = '0;
        k_nxt    = '0;
        rstart_nxt = '0;
        t_nxt    = '0;
        half_nxt = 1'b0;
      end
      S_INS: begin
        if (!vld_at(vld_r, cur_id) && 32'(slots_r) < CACHE_SLOTS) begin
          vld_nxt[cur_id[VID_AW-1:0]] = 1'b1;
          map_we    = 1'b1;
          slots_nxt = slots_r + 6'd1;
        end
        if (c_r == 2'd0 && 32'(bcnt_r) < BATCH_TRIANGLES) begin
          bat_we   = 1'b1;
          bcnt_nxt = bcnt_r + 6'd1;
        end
        c_nxt = c_r + 2'd1;
      end
      S_SCAN: begin
        if (!scan_stall) begin
          if (scan_v) begin
            map_we    = 1'b1;
            map_waddr = sid_r;
            map_wdata = k_r[SLOT_W-1:0];
            if (k_r == '0) begin
              rfirst_nxt = ID_W'(sid_r);
            end else if (scan_brk) begin
              ov_nxt     = 1'b1;
              okind_nxt  = CMD_LOAD;
              ofirst_nxt = rfirst_r;
              ocount_nxt = k_r - rstart_r;
              odest_nxt  = rstart_r[SLOT_W-1:0];
              ot_nxt     = '{default: '0};
              olast_nxt  = 1'b0;
              rstart_nxt = k_r;
              rfirst_nxt = ID_W'(sid_r);
            end
            prev_nxt = ID_W'(sid_r);
            k_nxt    = k_r + 6'd1;
          end
          sid_nxt = sid_r + 1'b1;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          okind_nxt  = CMD_LOAD;
          ofirst_nxt = rfirst_r;
          ocount_nxt = k_r - rstart_r;
          odest_nxt  = rstart_r[SLOT_W-1:0];
          ot_nxt     = '{default: '0};
          olast_nxt  = 1'b0;
        end
        c_nxt = '0;
      end
      S_TBAT: c_nxt = '0;
      S_TCOR: begin
        if (c_r != 2'd0) s_nxt[sidx] = map_rdata;
        c_nxt = c_r + 2'd1;
        if (c_r == 2'd3 && !half_r && !tri_done) begin
          half_nxt = 1'b1;
          t_nxt    = t_r + 6'd1;
        end
      end
      S_TEMIT: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          okind_nxt  = half_r ? CMD_TRI2 : CMD_TRI1;
          ofirst_nxt = '0;
          ocount_nxt = '0;
          odest_nxt  = '0;
          ot_nxt[0]  = s_r[0];
          ot_nxt[1]  = s_r[1];
          ot_nxt[2]  = s_r[2];
          ot_nxt[3]  = half_r ? s_r[3] : '0;
          ot_nxt[4]  = half_r ? s_r[4] : '0;
          ot_nxt[5]  = half_r ? s_r[5] : '0;
          olast_nxt  = emit_last;
          half_nxt   = 1'b0;
          t_nxt      = t_r + 6'd1;
          c_nxt      = '0;
          if (tri_done) begin
            vld_nxt   = '0;
            slots_nxt = '0;
            bcnt_nxt  = '0;
          end
        end
      end
      S_END: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          okind_nxt  = CMD_END;
          ofirst_nxt = '0;
          ocount_nxt = '0;
          odest_nxt  = '0;
          ot_nxt     = '{default: '0};
          olast_nxt  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= '0;
      slots_r <= '0;
      bcnt_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
      slots_r <= slots_nxt;
      bcnt_r  <= bcnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    id_r     <= id_nxt;
    c_r      <= c_nxt;
    sid_r    <= sid_nxt;
    k_r      <= k_nxt;
    rstart_r <= rstart_nxt;
    rfirst_r <= rfirst_nxt;
    prev_r   <= prev_nxt;
    t_r      <= t_nxt;
    half_r   <= half_nxt;
    s_r      <= s_nxt;
    okind_r  <= okind_nxt;
    ofirst_r <= ofirst_nxt;
    ocount_r <= ocount_nxt;
    odest_r  <= odest_nxt;
    ot_r     <= ot_nxt;
    olast_r  <= olast_nxt;
  end

`ifndef SYNTHESIS
  a_slots_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(slots_r) <= CACHE_SLOTS) else $error("slot count beyond cache size");
  a_batch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(bcnt_r) <= BATCH_TRIANGLES) else $error("batch count beyond store size");
  a_empty_batch: assert property (@(posedge clk) disable iff (!rst_n)
    (bcnt_r == '0) |-> (slots_r == '0)) else $error("slots held with empty batch");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ov_r) else $error("pending word dropped");
`endif

endmodule

// File: tb/vertex_cache_batcher_tb.sv
`timescale 1ns / 1ps
// testbench for vertex_cache_batcher: random and directed triangle and end words,
// a scoreboard class predicts load, triangle and end commands. needs vcb_pkg and the rtl
module vertex_cache_batcher_tb;
  import vcb_pkg::*;

  localparam int NSLOT = CACHE_SLOTS_DEF;
  localparam int NID   = VERTEX_IDS_DEF;
  localparam int NTRI  = BATCH_TRIANGLES_DEF;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ID_W-1:0]   first;
    logic [CNT_W-1:0]  count;
    logic [SLOT_W-1:0] dest;
    logic [SLOT_W-1:0] a0, a1, a2, b0, b1, b2;
    logic              last;
  } cmd_t;

  class batch_scoreboard;
    bit                 loaded [NID];
    logic [SLOT_W-1:0]  slot_of [NID];
    logic [ID_W-1:0]    tris [NTRI][3];
    int                 used;
    int                 ntri;
    cmd_t               pending [$];
    int                 errors;

    function void clear_batch();
      foreach (loaded[i]) loaded[i] = 0;
      used = 0;
      ntri = 0;
    endfunction

    function void push(cmd_t c);
      pending.push_back(c);
    endfunction

    function void flush_batch();
      int k, run_start, run_first, prev, t;
      cmd_t c;
      k = 0; run_start = 0; run_first = 0; prev = 0;
      if (ntri == 0) begin
        clear_batch();
        return;
      end
      for (int id = 0; id < NID; id++) begin
        if (!loaded[id] || k >= NSLOT) continue;
        slot_of[id] = SLOT_W'(k);
        if (k == 0) run_first = id;
        else if (id != prev + 1) begin
          c = '0; c.kind = CMD_LOAD; c.first = ID_W'(run_first);
          c.count = CNT_W'(k - run_start); c.dest = SLOT_W'(run_start);
          push(c);
          run_start = k;
          run_first = id;
        end
        prev = id;
        k++;
      end
      if (k > run_start) begin
        c = '0; c.kind = CMD_LOAD; c.first = ID_W'(run_first);
        c.count = CNT_W'(k - run_start); c.dest = SLOT_W'(run_start);
        push(c);
      end
      for (t = 0; t < ntri; t += 2) begin
        c = '0;
        c.kind = (t + 1 < ntri) ? CMD_TRI2 : CMD_TRI1;
        c.a0 = slot_of[tris[t][0]]; c.a1 = slot_of[tris[t][1]]; c.a2 = slot_of[tris[t][2]];
        if (t + 1 < ntri) begin
          c.b0 = slot_of[tris[t+1][0]]; c.b1 = slot_of[tris[t+1][1]];
          c.b2 = slot_of[tris[t+1][2]];
        end
        push(c);
      end
      clear_batch();
    endfunction

    function void note_word(logic req, logic [ID_W-1:0] va, logic [ID_W-1:0] vb,
                            logic [ID_W-1:0] vc);
      int before_n, need;
      logic [ID_W-1:0] ids [3];
      cmd_t c;
      before_n = pending.size();
      ids[0] = va; ids[1] = vb; ids[2] = vc;
      if (req == REQ_END) begin
        flush_batch();
        c = '0; c.kind = CMD_END;
        push(c);
      end else begin
        if (va >= NID || vb >= NID || vc >= NID) return;
        need = 0;
        for (int i = 0; i < 3; i++) if (!loaded[ids[i]]) need++;
        if (need + used > NSLOT || ntri >= NTRI) flush_batch();
        for (int i = 0; i < 3; i++)
          if (!loaded[ids[i]] && used < NSLOT) begin
            loaded[ids[i]] = 1;
            slot_of[ids[i]] = SLOT_W'(used);
            used++;
          end
        if (ntri < NTRI) begin
          for (int i = 0; i < 3; i++) tris[ntri][i] = ids[i];
          ntri++;
        end
      end
      if (pending.size() > before_n) pending[pending.size()-1].last = 1'b1;
    endfunction

    function void check_cmd(cmd_t got);
      cmd_t exp_c;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      exp_c = pending.pop_front();
      if (got !== exp_c) begin
        $display("%0t: word mismatch, expected %h, actual %h", $time, exp_c, got);
        $display("  kind %0d/%0d first %0d/%0d count %0d/%0d dest %0d/%0d last %0d/%0d",
                 exp_c.kind, got.kind, exp_c.first, got.first, exp_c.count, got.count,
                 exp_c.dest, got.dest, exp_c.last, got.last);
        $display("  tri %0d %0d %0d %0d %0d %0d / %0d %0d %0d %0d %0d %0d",
                 exp_c.a0, exp_c.a1, exp_c.a2, exp_c.b0, exp_c.b1, exp_c.b2,
                 got.a0, got.a1, got.a2, got.b0, got.b1, got.b2);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, in_req_type;
  logic [ID_W-1:0] in_corner_a, in_corner_b, in_corner_c;
  logic out_valid, out_ready;
  logic [1:0] out_cmd_kind;
  logic [ID_W-1:0] out_first_vertex;
  logic [CNT_W-1:0] out_load_count;
  logic [SLOT_W-1:0] out_dest_slot, out_tri0_s0, out_tri0_s1, out_tri0_s2;
  logic [SLOT_W-1:0] out_tri1_s0, out_tri1_s1, out_tri1_s2;
  logic out_last;

  vertex_cache_batcher uut (.*);

  batch_scoreboard sb = new();
  bit calm;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_cmd({out_cmd_kind, out_first_vertex, out_load_count, out_dest_slot,
                    out_tri0_s0, out_tri0_s1, out_tri0_s2, out_tri1_s0, out_tri1_s1,
                    out_tri1_s2, out_last});
    out_ready <= calm || ($urandom_range(99) >= 16);
  end

  // valid stays up between words unless an idle cycle comes in
  task automatic send_word(logic req, logic [ID_W-1:0] va, logic [ID_W-1:0] vb,
                           logic [ID_W-1:0] vc);
    while (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_corner_a <= va;
    in_corner_b <= vb;
    in_corner_c <= vc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(req, va, vb, vc);
  endtask

  task automatic send_tri(logic [ID_W-1:0] va, logic [ID_W-1:0] vb, logic [ID_W-1:0] vc);
    send_word(REQ_TRI, va, vb, vc);
  endtask

  function automatic logic [ID_W-1:0] pick_id(int lo, int hi);
    return ID_W'($urandom_range(hi, lo));
  endfunction

  initial begin
    int base, span, wait_n;
    sb.clear_batch();
    sb.errors = 0;
    calm = 0;
    rst_n = 0;
    in_valid = 0; in_req_type = 0;
    in_corner_a = 0; in_corner_b = 0; in_corner_c = 0;
    out_ready = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_word(REQ_END, 0, 0, 0);
    send_tri(0, 254, 127);
    send_tri(5, 5, 5);
    send_tri(1, 2, 3);
    send_tri(255, 1, 2);
    send_tri(1, 255, 2);
    send_tri(1, 2, 255);
    send_word(REQ_END, 8'hff, 8'hff, 8'hff);
    for (int i = 0; i < 11; i++)
      send_tri(ID_W'(3 * i + 10), ID_W'(3 * i + 11), ID_W'(3 * i + 12));
    send_tri(200, 201, 202);
    send_word(REQ_END, 0, 0, 0);
    for (int i = 0; i < 3; i++) send_tri(0, 1, 2);

    // random
    for (int n = 0; n < 350; n++) begin
      calm = (n >= 150 && n < 200);
      if (n % 40 == 0) begin
        base = $urandom_range(200);
        span = $urandom_range(1, 3) == 1 ? 8 : $urandom_range(20, 54);
      end
      case ($urandom_range(19))
        0: send_word(REQ_END, ID_W'($urandom), ID_W'($urandom), ID_W'($urandom));
        1: send_tri(ID_W'($urandom), ID_W'($urandom), ID_W'($urandom));
        2: send_tri(pick_id(0, 254), pick_id(0, 254), pick_id(0, 254));
        default: send_tri(pick_id(base, base + span), pick_id(base, base + span),
                          pick_id(base, base + span));
      endcase
    end
    send_word(REQ_END, 0, 0, 0);
    in_valid <= 1'b0;
    calm = 0;

    wait_n = 0;
    while (sb.pending.size() != 0 && wait_n < 200000) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (2000) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
rtl/core/vcb_pkg.sv
rtl/core/vcb_ram.sv
rtl/core/vertex_cache_batcher.sv
tb/vertex_cache_batcher_tb.sv
